// File: design/hsv_to_rgb_converter_defines.svh
// Assertion macros used by the converter's output stage, hsv_route.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSV_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hsv_pkg.sv
// Package with the widths, constants and stage payload types of the converter.
package hsv_pkg;

  localparam int FRAC_BITS = 12;

  // Magnitude width of an in-range saturation, value or sector fraction.
  localparam int VW  = FRAC_BITS + 1;
  localparam int VVW = VW + 8;
  localparam int SFW = 2 * VW;
  localparam int MPW = VVW + VW;
  localparam int NPW = VVW + SFW;

  localparam logic signed [17:0] UNIT    = 18'(1 << FRAC_BITS);
  localparam logic signed [17:0] HUE_MAX = 18'(6 << FRAC_BITS);
  localparam logic [VW-1:0]      UNIT_V  = VW'(1) << FRAC_BITS;
  localparam logic [SFW-1:0]     UNIT_SQ = SFW'(1) << (2 * FRAC_BITS);
  localparam logic [7:0]         LEVELS  = 8'd255;

  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;

  typedef struct packed {
    logic signed [15:0] hue;
    logic signed [15:0] saturation;
    logic signed [15:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic           black;
    logic           grey;
    logic [2:0]     sec;
    logic [VVW-1:0] vv;
    logic [VW-1:0]  oms;
    logic [SFW-1:0] sf;
  } s1_t;

  typedef struct packed {
    logic           black;
    logic           grey;
    logic [2:0]     sec;
    logic [VVW-1:0] vv;
    logic [SFW-1:0] np;
    logic [MPW-1:0] mprod;
  } s2_t;

  typedef struct packed {
    logic           black;
    logic           grey;
    logic [2:0]     sec;
    logic [7:0]     rv;
    logic [7:0]     mv;
    logic [NPW-1:0] nprod;
  } s3_t;

endpackage

// File: design/hsv_front.sv
// First pipeline stage: range checks, sector split and the first products.
module hsv_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  hsv_pkg::hsv_in_t in_data,
  output logic            in_ready,
  output logic            out_valid,
  output hsv_pkg::s1_t    out_data,
  input  logic            out_ready
);

  logic signed [17:0]       hx;
  logic signed [17:0]       sx;
  logic signed [17:0]       vx;
  logic [hsv_pkg::VW-1:0]   vmag;
  logic [hsv_pkg::VW-1:0]   smag;
  logic [hsv_pkg::VW-1:0]   fr;
  hsv_pkg::s1_t             s1_next;

  assign hx   = 18'(in_data.hue);
  assign sx   = 18'(in_data.saturation);
  assign vx   = 18'(in_data.brightness);
  assign vmag = vx[hsv_pkg::VW-1:0];
  assign smag = sx[hsv_pkg::VW-1:0];

  always_comb begin
    s1_next.black = (sx < 18'sd0) || (sx > hsv_pkg::UNIT) ||
                    (vx < 18'sd0) || (vx > hsv_pkg::UNIT);
    s1_next.grey  = (hx < 18'sd0) || (hx > hsv_pkg::HUE_MAX);
    s1_next.sec   = hx[hsv_pkg::FRAC_BITS+2:hsv_pkg::FRAC_BITS];
    // Even sectors run the fraction backwards, so a zero fraction becomes one.
    if (s1_next.sec[0]) begin
      fr = {1'b0, hx[hsv_pkg::FRAC_BITS-1:0]};
    end else begin
      fr = hsv_pkg::UNIT_V - {1'b0, hx[hsv_pkg::FRAC_BITS-1:0]};
    end
    s1_next.vv  = hsv_pkg::VVW'(vmag) * hsv_pkg::VVW'(hsv_pkg::LEVELS);
    s1_next.oms = hsv_pkg::UNIT_V - smag;
    s1_next.sf  = hsv_pkg::SFW'(smag) * hsv_pkg::SFW'(fr);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= s1_next;
    end
  end

endmodule

// File: design/hsv_mult.sv
// Second and third pipeline stages: the products behind m and n.
module hsv_mult (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  hsv_pkg::s1_t in_data,
  output logic         in_ready,
  output logic         out_valid,
  output hsv_pkg::s3_t out_data,
  input  logic         out_ready
);

  logic         s2_valid;
  hsv_pkg::s2_t s2;
  hsv_pkg::s2_t s2_next;
  hsv_pkg::s3_t s3_next;
  logic         s2_ready;

  always_comb begin
    s2_next.black = in_data.black;
    s2_next.grey  = in_data.grey;
    s2_next.sec   = in_data.sec;
    s2_next.vv    = in_data.vv;
    s2_next.np    = hsv_pkg::UNIT_SQ - in_data.sf;
    s2_next.mprod = hsv_pkg::MPW'(in_data.vv) * hsv_pkg::MPW'(in_data.oms);
  end

  always_comb begin
    s3_next.black = s2.black;
    s3_next.grey  = s2.grey;
    s3_next.sec   = s2.sec;
    s3_next.rv    = s2.vv[hsv_pkg::FRAC_BITS+7:hsv_pkg::FRAC_BITS];
    s3_next.mv    = s2.mprod[2*hsv_pkg::FRAC_BITS+7:2*hsv_pkg::FRAC_BITS];
    s3_next.nprod = hsv_pkg::NPW'(s2.vv) * hsv_pkg::NPW'(s2.np);
  end

  // A stage may load whenever it is empty or its content moves on.
  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s2_valid <= in_valid;
      end
      if (s2_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s2 <= s2_next;
    end
    if (s2_ready && s2_valid) begin
      out_data <= s3_next;
    end
  end

endmodule

// File: design/hsv_route.sv
// Output stage: scales n and routes v, n and m to the color channels.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_route (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  hsv_pkg::s3_t in_data,
  output logic         in_ready,
  output logic         out_valid,
  output hsv_pkg::rgb_t out_data,
  input  logic         out_ready
);

  logic [7:0]    nv;
  hsv_pkg::rgb_t rgb_next;

  assign nv = in_data.nprod[3*hsv_pkg::FRAC_BITS+7:3*hsv_pkg::FRAC_BITS];

  always_comb begin
    priority if (in_data.black) begin
      rgb_next = '0;
    end else if (in_data.grey) begin
      rgb_next = '{red: in_data.rv, green: in_data.rv, blue: in_data.rv};
    end else begin
      // Sector six falls into the default arm together with sector zero.
      unique case (in_data.sec)
        hsv_pkg::SECTOR_1: rgb_next = '{red: nv, green: in_data.rv, blue: in_data.mv};
        hsv_pkg::SECTOR_2: rgb_next = '{red: in_data.mv, green: in_data.rv, blue: nv};
        hsv_pkg::SECTOR_3: rgb_next = '{red: in_data.mv, green: nv, blue: in_data.rv};
        hsv_pkg::SECTOR_4: rgb_next = '{red: nv, green: in_data.mv, blue: in_data.rv};
        hsv_pkg::SECTOR_5: rgb_next = '{red: in_data.rv, green: in_data.mv, blue: nv};
        default:           rgb_next = '{red: in_data.rv, green: nv, blue: in_data.mv};
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= rgb_next;
    end
  end

  `HSV_ASSERT_NEXT(a_black_is_zero, clk, rst,
                   in_valid && in_ready && in_data.black,
                   out_valid && (out_data == '0),
                   "black transaction gave a nonzero color")
  `HSV_ASSERT_NEXT(a_grey_is_flat, clk, rst,
                   in_valid && in_ready && !in_data.black && in_data.grey,
                   (out_data.red == out_data.green) && (out_data.green == out_data.blue),
                   "grey transaction gave unequal channels")
  `HSV_ASSERT_NOW(a_levels_ordered, clk, rst,
                  in_valid && !in_data.black && !in_data.grey,
                  (in_data.mv <= nv) && (nv <= in_data.rv),
                  "channel levels out of order m <= n <= v")

endmodule

// File: design/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB pixel converter.
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_stall    hsv_pkg::hsv_in_t (hue, saturation, brightness)
//   out       output      out_valid / out_stall  hsv_pkg::rgb_t (red, green, blue)
//
// One pixel enters every clock while in_stall is low; a result passes the front, s2, s3
// and output registers after the edge that accepts its transaction.
// The four register stages are set by the multiplier chain: v*255 and s*f, then
// v*255*(1-s), then v*255*(1-s*f), then the channel routing into the output register.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage loads when it is empty or its content moves on, so a stalled output
// still lets earlier stages fill, and a stall loses or repeats nothing.
module hsv_to_rgb_converter (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  hsv_pkg::hsv_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output hsv_pkg::rgb_t    out_data
);

  logic         front_ready;
  logic         s1_valid;
  hsv_pkg::s1_t s1_data;
  logic         mult_ready;
  logic         s3_valid;
  hsv_pkg::s3_t s3_data;
  logic         route_ready;

  assign in_stall = !front_ready;

  hsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (front_ready),
    .out_valid (s1_valid),
    .out_data  (s1_data),
    .out_ready (mult_ready)
  );

  hsv_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .in_ready  (mult_ready),
    .out_valid (s3_valid),
    .out_data  (s3_data),
    .out_ready (route_ready)
  );

  hsv_route u_route (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_data   (s3_data),
    .in_ready  (route_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (!out_stall)
  );

endmodule

// File: tb/hsv_to_rgb_converter_tb.sv
// Self-checking testbench for the HSV to RGB pixel converter.
module hsv_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = hsv_pkg::FRAC_BITS;
  localparam int UNIT = 1 << FB;
  localparam int HUE_TOP = 6 * UNIT;
  localparam longint UNIT_L = longint'(1) << FB;
  localparam int RANDOM_PIXELS = 1700;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    hsv_pkg::hsv_in_t pixel;
    hsv_pkg::rgb_t    color;
  } pending_color_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  hsv_pkg::hsv_in_t in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  hsv_pkg::rgb_t    out_data;

  hsv_pkg::hsv_in_t pixel_queue[$];
  bit               drain_mark[$];
  pending_color_t   color_expected[$];
  int               pixel_total;
  int               pixels_taken = 0;
  int               error_count = 0;
  logic             in_fire = 1'b0;
  int               burst_left = 1;
  int               gap_left = 0;
  stall_mode_t      stall_mode = STALL_NONE;
  int               stall_span = 0;

  hsv_to_rgb_converter dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Exact fixed point color of one pixel, channels are floor(level * 255).
  function automatic hsv_pkg::rgb_t hsv_pixel_color(hsv_pkg::hsv_in_t px);
    longint h, s, v;
    longint unsigned uv, us, sec, frac, full_lvl, m_lvl, n_lvl;
    hsv_pkg::rgb_t c;
    h = $signed(px.hue);
    s = $signed(px.saturation);
    v = $signed(px.brightness);
    if (s < 0 || s > UNIT_L || v < 0 || v > UNIT_L) begin
      return '0;
    end
    uv = v;
    us = s;
    full_lvl = (uv * 255) >> FB;
    if (h < 0 || h > 6 * UNIT_L) begin
      c.red   = full_lvl[7:0];
      c.green = full_lvl[7:0];
      c.blue  = full_lvl[7:0];
      return c;
    end
    sec  = longint'(h) >> FB;
    frac = longint'(h) & (UNIT_L - 1);
    // Even sectors run the fraction backwards, so an integer hue there gives n = m.
    if (!sec[0]) begin
      frac = UNIT_L - frac;
    end
    m_lvl = (uv * (UNIT_L - us) * 255) >> (2 * FB);
    n_lvl = (uv * (UNIT_L * UNIT_L - us * frac) * 255) >> (3 * FB);
    case (sec[2:0])
      hsv_pkg::SECTOR_1: c = {n_lvl[7:0], full_lvl[7:0], m_lvl[7:0]};
      hsv_pkg::SECTOR_2: c = {m_lvl[7:0], full_lvl[7:0], n_lvl[7:0]};
      hsv_pkg::SECTOR_3: c = {m_lvl[7:0], n_lvl[7:0], full_lvl[7:0]};
      hsv_pkg::SECTOR_4: c = {n_lvl[7:0], m_lvl[7:0], full_lvl[7:0]};
      hsv_pkg::SECTOR_5: c = {full_lvl[7:0], m_lvl[7:0], n_lvl[7:0]};
      default:           c = {full_lvl[7:0], n_lvl[7:0], m_lvl[7:0]};
    endcase
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    error_count++;
  endtask

  task automatic push_pixel(int h, int s, int v, bit drain);
    hsv_pkg::hsv_in_t px;
    px.hue        = 16'(h);
    px.saturation = 16'(s);
    px.brightness = 16'(v);
    pixel_queue.push_back(px);
    drain_mark.push_back(drain);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Sender: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() == 0 ||
                   (drain_mark[0] && color_expected.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_data <= pixel_queue.pop_front();
        void'(drain_mark.pop_front());
        in_valid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            8:          gap_left = $urandom_range(10, 30);
            default:    gap_left = $urandom_range(1, 4);
          endcase
        end
      end
    end
  end

  // Receiver: stall pattern switches between modes at random.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(20, 300);
    end
    stall_span = stall_span - 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall <= $urandom_range(0, 1);
      default:     out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Checks results against the oldest expected color, then records new pixels.
  always @(posedge clk) begin
    pending_color_t want;
    in_fire <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (color_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = color_expected.pop_front();
        if (out_data.red !== want.color.red)
          report_mismatch($sformatf("red %h want %h for hsv %h", out_data.red,
                                    want.color.red, want.pixel));
        if (out_data.green !== want.color.green)
          report_mismatch($sformatf("green %h want %h for hsv %h", out_data.green,
                                    want.color.green, want.pixel));
        if (out_data.blue !== want.color.blue)
          report_mismatch($sformatf("blue %h want %h for hsv %h", out_data.blue,
                                    want.color.blue, want.pixel));
      end
    end
    if (!rst && in_valid && !in_stall) begin
      want.pixel = in_data;
      want.color = hsv_pixel_color(in_data);
      color_expected.push_back(want);
      pixels_taken++;
    end
  end

  initial begin
    int h, s, v, kind;
    // Directed pixels: every sector, the range edges and the special hues.
    push_pixel(0, UNIT, UNIT, 1'b0);
    push_pixel(UNIT / 2, UNIT, UNIT, 1'b0);
    push_pixel(UNIT + UNIT / 4, UNIT, UNIT - 1, 1'b0);
    push_pixel(2 * UNIT + 1000, UNIT / 2, UNIT, 1'b0);
    push_pixel(3 * UNIT + 2047, UNIT, 3000, 1'b0);
    push_pixel(4 * UNIT + 3000, 1234, UNIT, 1'b0);
    push_pixel(5 * UNIT + 4095, UNIT, UNIT, 1'b0);
    push_pixel(HUE_TOP, UNIT, UNIT, 1'b0);
    push_pixel(2 * UNIT, UNIT / 3, UNIT, 1'b0);
    push_pixel(4 * UNIT, UNIT, 2500, 1'b0);
    push_pixel(3 * UNIT, UNIT / 2, UNIT, 1'b0);
    push_pixel(-1, UNIT / 2, 3000, 1'b0);
    push_pixel(HUE_TOP + 1, UNIT, UNIT, 1'b0);
    push_pixel(-32768, 0, UNIT, 1'b0);
    push_pixel(32767, UNIT, UNIT, 1'b0);
    push_pixel(UNIT, -1, UNIT, 1'b0);
    push_pixel(UNIT, UNIT + 1, UNIT, 1'b0);
    push_pixel(UNIT, UNIT, -1, 1'b0);
    push_pixel(UNIT, UNIT, UNIT + 1, 1'b0);
    push_pixel(UNIT, -32768, 32767, 1'b0);
    push_pixel(UNIT, 32767, UNIT, 1'b0);
    push_pixel(UNIT, UNIT, -32768, 1'b0);
    push_pixel(5 * UNIT / 2, 0, 2000, 1'b0);
    push_pixel(UNIT + 7, UNIT, 0, 1'b0);
    push_pixel(HUE_TOP - 1, UNIT / 3, UNIT - 1, 1'b0);
    // Random pixels, mostly in range; the rest hit edges or use raw bit patterns.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      kind = $urandom_range(0, 15);
      h = $urandom_range(0, HUE_TOP);
      s = $urandom_range(0, UNIT);
      v = $urandom_range(0, UNIT);
      case (kind)
        0: h = $urandom;
        1: s = $urandom;
        2: v = $urandom;
        3: begin
          h = $urandom;
          s = $urandom;
          v = $urandom;
        end
        4: h = $urandom_range(0, 6) * UNIT;
        5: begin
          s = $urandom_range(0, 1) * UNIT;
          v = $urandom_range(0, 1) ? UNIT : $urandom_range(UNIT - 2, UNIT + 2);
        end
        6: h = $urandom_range(0, 1) ? $urandom_range(HUE_TOP - 2, HUE_TOP + 2)
                                    : $urandom_range(0, 4) - 2;
        default: ;
      endcase
      push_pixel(h, s, v, i == 0 || i == RANDOM_PIXELS / 2);
    end
    pixel_total = pixel_queue.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pixels_taken == pixel_total);
    wait (color_expected.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: hsv_to_rgb_converter.f
+incdir+design
design/hsv_pkg.sv
design/hsv_front.sv
design/hsv_mult.sv
design/hsv_route.sv
design/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_converter_tb.sv
